/* design/assert_macros.svh */
// Assertion macros shared by the ycl design files.
// Pulled in by `include where a module checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold at a clock edge out of reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// ante at an edge implies cons at the same edge
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// ante at an edge implies cons at the next edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/ycl_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the table index function for the YUYV classifier.
// No dependencies.
package ycl_pkg;

	localparam int unsigned MAX_WIDTH_DEF  = 2048;
	localparam int unsigned MAX_HEIGHT_DEF = 2048;

	localparam int unsigned LUT_AW    = 18;
	localparam int unsigned LUT_DEPTH = 1 << LUT_AW;
	localparam int unsigned LABEL_W   = 8;
	localparam int unsigned WORD_W    = 32;

	// config register file
	localparam int unsigned SCALE_W    = 2;
	localparam int unsigned DIM_W      = 12;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned DIM_EXT_W  = 13;

	localparam logic [CFG_IDX_W-1:0] REG_SCALE_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_PIXELS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_LINES = 2'd2;

	localparam logic [SCALE_W-1:0] SCALE_FULL    = 2'd0;
	localparam logic [SCALE_W-1:0] SCALE_HALF    = 2'd1;
	localparam logic [SCALE_W-1:0] SCALE_QUARTER = 2'd2;

	localparam logic [DIM_W-1:0] WIDTH_RST  = 12'd640;
	localparam logic [DIM_W-1:0] HEIGHT_RST = 12'd480;

	localparam logic       MODE_PIXEL = 1'b0;

	// result buffer
	localparam int unsigned OUT_DEPTH = 4;
	localparam int unsigned OUT_PTR_W = 2;
	localparam int unsigned OUT_CNT_W = 3;

	typedef struct packed {
		logic [SCALE_W-1:0] scale;
		logic [DIM_W-1:0]   width;
		logic [DIM_W-1:0]   height;
	} cfg_t;

	typedef struct packed {
		logic               en;
		logic [LUT_AW-1:0]  addr;
		logic [LABEL_W-1:0] data;
	} lut_wr_t;

	typedef struct packed {
		logic              en;
		logic [LUT_AW-1:0] addr;
	} lut_rd_t;

	typedef struct packed {
		logic valid;
		logic last;
	} res_t;

	// Y[7:2] -> 17:12, U[7:2] -> 11:6, V[7:2] -> 5:0
	function automatic logic [LUT_AW-1:0] lut_index(input logic [7:0] y,
			input logic [WORD_W-1:0] w);
		lut_index = {y[7:2], w[15:10], w[31:26]};
	endfunction

endpackage

/* design/ycl_ifs.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces: input requests and label results.
// Depends on ycl_pkg.
interface ycl_in_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  mode;
	logic [ycl_pkg::WORD_W-1:0]            pixel_word;
	logic [ycl_pkg::LUT_AW-1:0]            table_address;
	logic [ycl_pkg::LABEL_W-1:0]           table_label;

	modport source (output valid, mode, pixel_word, table_address, table_label,
		input ready);
	modport sink (input valid, mode, pixel_word, table_address, table_label,
		output ready);
endinterface

interface ycl_out_if;
	logic                        valid;
	logic                        ready;
	logic [ycl_pkg::LABEL_W-1:0] label;
	logic                        last;

	modport source (output valid, label, last, input ready);
	modport sink (input valid, label, last, output ready);
endinterface

/* design/yuyv_color_lut_classifier.sv */
`timescale 1ns / 1ps
// Top level of the YUYV color class classifier: config registers and wiring.
// Depends on ycl_pkg, ycl_ifs, ycl_issue, ycl_lut_mem and ycl_out_fifo.
//
//   channel   dir  handshake      carries
//   in_ch     in   valid/ready    mode, pixel_word, table_address, table_label
//   out_ch    out  valid/ready    label, last
//   cfg       in   cfg_we         cfg_index, cfg_data (no read-back)
//
// Flow: in_ch takes table writes and pixel words while the result buffer has
// room; a full-rate pixel word holds off the next request for its Y2 read, since
// its Y1 and Y2 labels share the one table read port. A label reaches out_ch via
// table read, then buffer write; a full-rate word's Y2 label follows its Y1 label.
// Reset: arst_n clears counters, config (scale 0, 640 x 480) and the result
// buffer; the table itself is not cleared and needs no sweep.
// Stalls: a four-entry result buffer absorbs output backpressure; in_ch.ready
// drops while the Y2 read of a full-rate word is pending and while the buffer plus
// reads in flight would fill it.

module yuyv_color_lut_classifier #(
	parameter int unsigned MAX_WIDTH  = ycl_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = ycl_pkg::MAX_HEIGHT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	ycl_in_if.sink                        in_ch,
	ycl_out_if.source                     out_ch,
	input  logic                          cfg_we,
	input  logic [ycl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ycl_pkg::DIM_W-1:0]     cfg_data
);

	ycl_pkg::cfg_t               cfg_q;
	ycl_pkg::lut_wr_t            wr;
	ycl_pkg::lut_rd_t            rd;
	ycl_pkg::res_t               res_s1;
	logic [ycl_pkg::LABEL_W-1:0] rdata;
	logic                        room;

	// config register file; an index past the list is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale  <= ycl_pkg::SCALE_FULL;
			cfg_q.width  <= ycl_pkg::WIDTH_RST;
			cfg_q.height <= ycl_pkg::HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ycl_pkg::REG_SCALE_MODE: begin
					cfg_q.scale <= cfg_data[ycl_pkg::SCALE_W-1:0];
				end
				ycl_pkg::REG_WIDTH_PIXELS: begin
					cfg_q.width <= cfg_data;
				end
				ycl_pkg::REG_HEIGHT_LINES: begin
					cfg_q.height <= cfg_data;
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// decode, frame counters, subsampling, table access issue
	ycl_issue #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_issue (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.room   (room),
		.in_ch  (in_ch),
		.wr     (wr),
		.rd     (rd),
		.res_s1 (res_s1)
	);

	// 256K-entry class table
	ycl_lut_mem u_lut_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.rd     (rd),
		.rdata  (rdata)
	);

	// label buffer toward the output channel
	ycl_out_fifo u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.res_s1 (res_s1),
		.rdata  (rdata),
		.room   (room),
		.out_ch (out_ch)
	);

endmodule

/* design/ycl_lut_mem.sv */
`timescale 1ns / 1ps
// Class table: 256K x 8 synchronous RAM, one write port, one registered read port.
// Depends on ycl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ycl_lut_mem (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ycl_pkg::lut_wr_t            wr,
	input  ycl_pkg::lut_rd_t            rd,
	output logic [ycl_pkg::LABEL_W-1:0] rdata
);

	logic [ycl_pkg::LABEL_W-1:0] mem [ycl_pkg::LUT_DEPTH];
	logic [ycl_pkg::LABEL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rdata_q <= mem[rd.addr];
		end
	end

	assign rdata = rdata_q;

	// issue logic serializes table writes and reads
	`ASSERT_NEVER(a_no_rw_same_cycle, clk, arst_n, wr.en && rd.en, "table read and write collide")

endmodule

/* design/ycl_out_fifo.sv */
`timescale 1ns / 1ps
// Result buffer: small FIFO of labels between the table read and the output channel.
// Depends on ycl_pkg, ycl_ifs and assert_macros.svh.
`include "assert_macros.svh"

module ycl_out_fifo (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ycl_pkg::res_t               res_s1,
	input  logic [ycl_pkg::LABEL_W-1:0] rdata,
	output logic                        room,
	ycl_out_if.source                   out_ch
);

	logic [ycl_pkg::LABEL_W-1:0]   label_q [ycl_pkg::OUT_DEPTH];
	logic                          last_q  [ycl_pkg::OUT_DEPTH];
	logic [ycl_pkg::OUT_PTR_W-1:0] wptr_q, rptr_q;
	logic [ycl_pkg::OUT_CNT_W-1:0] count_q;
	logic                          push, pop;

	assign push = res_s1.valid;
	assign pop  = out_ch.valid && out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			count_q <= count_q + ycl_pkg::OUT_CNT_W'(push) - ycl_pkg::OUT_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			label_q[wptr_q] <= rdata;
			last_q[wptr_q]  <= res_s1.last;
		end
	end

	// a read issued now is registered, then written into the buffer; count what is already on its way
	assign room = (count_q + ycl_pkg::OUT_CNT_W'(push)) <
		ycl_pkg::OUT_CNT_W'(ycl_pkg::OUT_DEPTH);

	assign out_ch.valid = (count_q != '0);
	assign out_ch.label = label_q[rptr_q];
	assign out_ch.last  = last_q[rptr_q];

	`ASSERT_NEVER(a_no_overflow, clk, arst_n, push && !pop && (count_q == ycl_pkg::OUT_CNT_W'(ycl_pkg::OUT_DEPTH)), "result buffer overflow")
	`ASSERT_NEVER(a_no_underflow, clk, arst_n, pop && (count_q == '0), "result buffer underflow")

endmodule

/* design/ycl_issue.sv */
`timescale 1ns / 1ps
// Request decode: frame counters, subsampling decision, table write and read issue.
// Depends on ycl_pkg, ycl_ifs and assert_macros.svh.
`include "assert_macros.svh"

module ycl_issue #(
	parameter int unsigned MAX_WIDTH  = ycl_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = ycl_pkg::MAX_HEIGHT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ycl_pkg::cfg_t    cfg,
	input  logic             room,
	ycl_in_if.sink           in_ch,
	output ycl_pkg::lut_wr_t wr,
	output ycl_pkg::lut_rd_t rd,
	output ycl_pkg::res_t    res_s1
);

	localparam int unsigned MAX_WORDS = MAX_WIDTH / 2;
	localparam int unsigned WRD_W = $clog2(MAX_WORDS + 1);
	localparam int unsigned COL_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int unsigned LIN_W = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int unsigned CMP_W = LIN_W + 2;
	localparam int unsigned EW    = ycl_pkg::DIM_EXT_W;

	logic [COL_W-1:0]           col_q;
	logic [ROW_W-1:0]           row_q;
	logic                       pend_q;
	logic [ycl_pkg::LUT_AW-1:0] idx2_q;

	logic [EW-1:0]    wsat, hsat;
	logic [WRD_W-1:0] words, col, col_inc;
	logic [LIN_W-1:0] lines, row, row_inc;
	logic [CMP_W-1:0] row_x, lines_x, step, mask;
	logic [WRD_W:0]   col_x2;
	logic             full, keep, wrap;
	logic             accept, is_pix, second;

	// frame geometry, saturated to MAX_WIDTH and MAX_HEIGHT
	always_comb begin
		wsat = ({1'b0, cfg.width} > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : {1'b0, cfg.width};
		hsat = ({1'b0, cfg.height} > EW'(MAX_HEIGHT)) ? EW'(MAX_HEIGHT) : {1'b0, cfg.height};
		words = (wsat[EW-1:1] == '0) ? WRD_W'(1) : WRD_W'(wsat[EW-1:1]);
		lines = (hsat == '0) ? LIN_W'(1) : LIN_W'(hsat);
	end

	// stale counters past a shrunken frame restart at zero
	always_comb begin
		col = (WRD_W'(col_q) >= words) ? '0 : WRD_W'(col_q);
		row = (LIN_W'(row_q) >= lines) ? '0 : LIN_W'(row_q);
		full = (cfg.scale == ycl_pkg::SCALE_FULL);
		step = (cfg.scale == ycl_pkg::SCALE_HALF) ? CMP_W'(2) : CMP_W'(4);
		mask = step - CMP_W'(1);
		row_x = CMP_W'(row);
		lines_x = CMP_W'(lines);
		col_x2 = (WRD_W + 1)'(col) + (WRD_W + 1)'(2);
		keep = ((row_x & mask) == '0) && ((row_x + step) <= lines_x);
		if (cfg.scale != ycl_pkg::SCALE_HALF) begin
			keep = keep && !col[0] && (col_x2 <= (WRD_W + 1)'(words));
		end
		keep = keep || full;
		col_inc = col + WRD_W'(1);
		row_inc = row + LIN_W'(1);
		wrap = (col_inc >= words);
	end

	assign in_ch.ready = !pend_q && room;
	assign accept = in_ch.valid && in_ch.ready;
	assign is_pix = accept && (in_ch.mode == ycl_pkg::MODE_PIXEL);
	assign second = pend_q && room;

	always_comb begin
		wr.en   = accept && (in_ch.mode != ycl_pkg::MODE_PIXEL);
		wr.addr = in_ch.table_address;
		wr.data = in_ch.table_label;
		rd.en   = second || (is_pix && keep);
		rd.addr = pend_q ? idx2_q : ycl_pkg::lut_index(in_ch.pixel_word[7:0], in_ch.pixel_word);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			pend_q <= 1'b0;
			res_s1 <= '0;
		end else begin
			res_s1.valid <= rd.en;
			res_s1.last  <= pend_q || !full;
			if (second) begin
				pend_q <= 1'b0;
			end else if (is_pix && full) begin
				pend_q <= 1'b1;
			end
			if (is_pix) begin
				if (wrap) begin
					col_q <= '0;
					row_q <= (row_inc >= lines) ? '0 : ROW_W'(row_inc);
				end else begin
					col_q <= COL_W'(col_inc);
					row_q <= ROW_W'(row);
				end
			end
		end
	end

	// Y2 index held for the second read of a full-rate word
	always_ff @(posedge clk) begin
		if (is_pix) begin
			idx2_q <= ycl_pkg::lut_index(in_ch.pixel_word[23:16], in_ch.pixel_word);
		end
	end

	`ASSERT_IMPLY(a_ready_not_pending, clk, arst_n, in_ch.ready, !pend_q, "request taken while Y2 read pending")
	`ASSERT_NEXT(a_full_sets_pending, clk, arst_n, is_pix && full, pend_q && !res_s1.last, "full-rate word did not queue Y2 read")
	`ASSERT_NEXT(a_second_is_last, clk, arst_n, second, res_s1.valid && res_s1.last && !pend_q, "Y2 read not marked last")

endmodule
